[rtl/core/sspcp_pkg.sv]
// ----------------------------------------------------------------------------
// sspcp_pkg
// Shared constants for the serial setpoint command parser: widths, ASCII
// codes, command codes and value limits.
// ----------------------------------------------------------------------------
package sspcp_pkg;

    localparam int BYTE_W         = 8;
    localparam int VALUE_W        = 14;
    localparam int COUNT_W        = 3;
    localparam int CMD_W          = 2;
    localparam int MAX_DIGITS_DEF = 7;

    // value*10 + 9 with value at most TOO_LARGE
    localparam int ACC_W = 17;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 14'd9999;
    localparam logic [VALUE_W-1:0] TOO_LARGE   = 14'd10000;

    localparam logic [BYTE_W-1:0] CH_S_UC = 8'h53;
    localparam logic [BYTE_W-1:0] CH_S_LC = 8'h73;
    localparam logic [BYTE_W-1:0] CH_A_UC = 8'h41;
    localparam logic [BYTE_W-1:0] CH_A_LC = 8'h61;
    localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;

    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALARM = 2'd2;

    localparam logic TARGET_SETPOINT = 1'b0;
    localparam logic TARGET_ALARM    = 1'b1;

endpackage

[rtl/core/sspcp_if.sv]
// ----------------------------------------------------------------------------
// sspcp interfaces
// Valid/ready channels for received bytes and for parsed commands.
// ----------------------------------------------------------------------------
interface sspcp_byte_if;
    logic                              valid;
    logic                              ready;
    logic [sspcp_pkg::BYTE_W-1:0]      rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sspcp_cmd_if;
    logic                              valid;
    logic                              ready;
    logic                              target;
    logic [sspcp_pkg::VALUE_W-1:0]     value;

    modport source (output valid, output target, output value, input ready);
    modport sink   (input valid, input target, input value, output ready);
endinterface

[rtl/core/serial_setpoint_command_parser_unit.sv]
// ----------------------------------------------------------------------------
// serial_setpoint_command_parser_unit
// Parses 'S'/'A' commands with decimal values terminated by CR or LF.
// ----------------------------------------------------------------------------
// A line end byte passes the byte register, then the result register.
// Throughput: one byte per cycle; the byte register stalls only while a
//   result waits in the output register and the sink holds ready low.
// Reset: rst_n clears both valid bits, the pending command, the digit
//   count and the accumulated value.
module serial_setpoint_command_parser_unit #(
    parameter int MAX_DIGITS = sspcp_pkg::MAX_DIGITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    sspcp_byte_if.sink          rx,
    sspcp_cmd_if.source         result
);

    localparam logic [sspcp_pkg::COUNT_W-1:0] MAX_CNT = sspcp_pkg::COUNT_W'(MAX_DIGITS);

    // byte register
    logic                                 in_valid_reg;
    logic [sspcp_pkg::BYTE_W-1:0]         in_byte_reg;

    // parser state
    logic [sspcp_pkg::CMD_W-1:0]          cmd_reg,   cmd_next;
    logic [sspcp_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [sspcp_pkg::VALUE_W-1:0]        acc_reg,   acc_next;

    // result register
    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_target_reg;
    logic [sspcp_pkg::VALUE_W-1:0]        out_value_reg;

    logic                                 advance;
    logic                                 is_set, is_alarm, is_digit, is_eol;
    logic                                 emit;
    logic [sspcp_pkg::ACC_W-1:0]          acc_wide;
    logic [sspcp_pkg::ACC_W-1:0]          acc_mul;

    // the byte register moves on whenever the result register can take a result
    assign advance  = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready = !in_valid_reg || !out_valid_reg || result.ready;

    assign is_set   = (in_byte_reg == sspcp_pkg::CH_S_UC) || (in_byte_reg == sspcp_pkg::CH_S_LC);
    assign is_alarm = (in_byte_reg == sspcp_pkg::CH_A_UC) || (in_byte_reg == sspcp_pkg::CH_A_LC);
    assign is_digit = (in_byte_reg >= sspcp_pkg::CH_0) && (in_byte_reg <= sspcp_pkg::CH_9);
    assign is_eol   = (in_byte_reg == sspcp_pkg::CH_LF) || (in_byte_reg == sspcp_pkg::CH_CR);

    // value*10 + digit as shift-add
    assign acc_wide = sspcp_pkg::ACC_W'(acc_reg);
    assign acc_mul  = (acc_wide << 3) + (acc_wide << 1)
                    + sspcp_pkg::ACC_W'(in_byte_reg[3:0]);

    assign emit = is_eol && (cmd_reg != sspcp_pkg::CMD_NONE) && (count_reg != '0)
               && (acc_reg <= sspcp_pkg::VALUE_LIMIT);

    always_comb
    begin
        cmd_next   = cmd_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        if (is_set || is_alarm)
        begin
            cmd_next   = is_alarm ? sspcp_pkg::CMD_ALARM : sspcp_pkg::CMD_SET;
            count_next = '0;
            acc_next   = '0;
        end
        else if (is_digit)
        begin
            if ((cmd_reg != sspcp_pkg::CMD_NONE) && (count_reg < MAX_CNT))
            begin
                acc_next   = (acc_mul > sspcp_pkg::ACC_W'(sspcp_pkg::TOO_LARGE))
                           ? sspcp_pkg::TOO_LARGE : acc_mul[sspcp_pkg::VALUE_W-1:0];
                count_next = count_reg + 1'b1;
            end
        end
        else if (is_eol && (cmd_reg != sspcp_pkg::CMD_NONE) && (count_reg != '0))
        begin
            cmd_next   = sspcp_pkg::CMD_NONE;
            count_next = '0;
            acc_next   = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= sspcp_pkg::CMD_NONE;
            count_reg     <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                cmd_reg   <= cmd_next;
                count_reg <= count_next;
                acc_reg   <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance && emit)
        begin
            out_target_reg <= (cmd_reg == sspcp_pkg::CMD_ALARM)
                            ? sspcp_pkg::TARGET_ALARM : sspcp_pkg::TARGET_SETPOINT;
            out_value_reg  <= acc_reg;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.target = out_target_reg;
    assign result.value  = out_value_reg;

endmodule

[rtl/core/sspcp_checker.sv]
// ----------------------------------------------------------------------------
// sspcp_checker
// Port-level checks on the command parser, bound to the parser unit.
// ----------------------------------------------------------------------------
module sspcp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rx_valid,
    input  logic                            rx_ready,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            out_target,
    input  logic [sspcp_pkg::VALUE_W-1:0]   out_value
);

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_target) && $stable(out_value))
        else $error("result beat changed while stalled");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_value <= sspcp_pkg::VALUE_LIMIT)
        else $error("result value above limit");

    // input only backs up behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // an idle input with nothing queued cannot stall
    a_rx_unused: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_valid && !out_valid |-> rx_ready)
        else $error("input not ready while empty");

endmodule

bind serial_setpoint_command_parser_unit sspcp_checker u_sspcp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_valid   (rx.valid),
    .rx_ready   (rx.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_target (result.target),
    .out_value  (result.value)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial setpoint command parser. Byte beats
// from a queue drive the rx channel with random gaps. Each accepted byte
// runs through a parser model kept here, which queues the command it
// expects. A monitor compares every result beat with that queue while the
// result sink stalls at random.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                          target;
        logic [sspcp_pkg::VALUE_W-1:0] value;
    } cmd_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    sspcp_byte_if rx_ch ();
    sspcp_cmd_if  cmd_ch ();

    serial_setpoint_command_parser_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (cmd_ch)
    );

    always #5 clk = ~clk;

    // Byte stream still to send, and commands the parser should emit
    logic [sspcp_pkg::BYTE_W-1:0] tx_bytes[$];
    cmd_beat_t                    cmds_expected[$];

    // Parser model state
    logic [sspcp_pkg::CMD_W-1:0]   pend_cmd;
    logic [sspcp_pkg::COUNT_W-1:0] digit_cnt;
    logic [sspcp_pkg::VALUE_W-1:0] acc_value;

    int total_bytes;
    int beats_sent;
    int useful;
    int mismatches;

    int tx_gap;
    int tx_cycle;
    bit tx_quiet;
    int rdy_hold;
    int rdy_cycle;
    bit rdy_quiet;

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void parse_byte(input logic [sspcp_pkg::BYTE_W-1:0] c);
        logic [sspcp_pkg::ACC_W-1:0] sum;
        if (c == sspcp_pkg::CH_S_UC || c == sspcp_pkg::CH_S_LC)
        begin
            pend_cmd  = sspcp_pkg::CMD_SET;
            digit_cnt = '0;
            acc_value = '0;
        end
        else if (c == sspcp_pkg::CH_A_UC || c == sspcp_pkg::CH_A_LC)
        begin
            pend_cmd  = sspcp_pkg::CMD_ALARM;
            digit_cnt = '0;
            acc_value = '0;
        end
        else if (c >= sspcp_pkg::CH_0 && c <= sspcp_pkg::CH_9)
        begin
            if (pend_cmd != sspcp_pkg::CMD_NONE && digit_cnt < sspcp_pkg::MAX_DIGITS_DEF)
            begin
                sum = sspcp_pkg::ACC_W'(acc_value) * sspcp_pkg::ACC_W'(10)
                    + sspcp_pkg::ACC_W'(c - sspcp_pkg::CH_0);
                if (sum > sspcp_pkg::ACC_W'(sspcp_pkg::TOO_LARGE))
                    sum = sspcp_pkg::ACC_W'(sspcp_pkg::TOO_LARGE);
                acc_value = sum[sspcp_pkg::VALUE_W-1:0];
                digit_cnt = digit_cnt + 1'b1;
            end
        end
        else if ((c == sspcp_pkg::CH_LF || c == sspcp_pkg::CH_CR)
                 && pend_cmd != sspcp_pkg::CMD_NONE && digit_cnt != 0)
        begin
            // too-large values are dropped without a result
            if (acc_value <= sspcp_pkg::VALUE_LIMIT)
                cmds_expected.push_back('{
                    target: (pend_cmd == sspcp_pkg::CMD_ALARM)
                            ? sspcp_pkg::TARGET_ALARM : sspcp_pkg::TARGET_SETPOINT,
                    value:  acc_value});
            pend_cmd  = sspcp_pkg::CMD_NONE;
            digit_cnt = '0;
            acc_value = '0;
        end
    endfunction

    function automatic void push_byte(input logic [sspcp_pkg::BYTE_W-1:0] b);
        tx_bytes.push_back(b);
        useful++;
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void push_digits(input int n);
        for (int i = 0; i < n; i++)
            push_byte(sspcp_pkg::CH_0 + sspcp_pkg::BYTE_W'($urandom_range(0, 9)));
    endfunction

    function automatic void push_cmd_letter();
        case ($urandom_range(0, 3))
            0:       push_byte(sspcp_pkg::CH_S_UC);
            1:       push_byte(sspcp_pkg::CH_S_LC);
            2:       push_byte(sspcp_pkg::CH_A_UC);
            default: push_byte(sspcp_pkg::CH_A_LC);
        endcase
    endfunction

    function automatic void push_line_end();
        case ($urandom_range(0, 2))
            0:       push_byte(sspcp_pkg::CH_CR);
            1:       push_byte(sspcp_pkg::CH_LF);
            default:
            begin
                push_byte(sspcp_pkg::CH_CR);
                push_byte(sspcp_pkg::CH_LF);
            end
        endcase
    endfunction

    // Byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
        end
        else
        begin
            tx_cycle++;
            if (tx_cycle % 400 == 0)
                tx_quiet = ($urandom_range(0, 2) == 0);
            if (rx_ch.valid && rx_ch.ready)
            begin
                parse_byte(rx_ch.rx_byte);
                beats_sent++;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    rx_ch.valid <= 1'b0;
                end
                else if (tx_bytes.size() != 0)
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= tx_bytes.pop_front();
                    tx_gap = pick_gap(tx_quiet);
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.ready <= 1'b0;
        end
        else
        begin
            rdy_cycle++;
            if (rdy_cycle % 350 == 0)
                rdy_quiet = ($urandom_range(0, 2) == 0);
            if (rdy_hold > 0)
            begin
                rdy_hold--;
                cmd_ch.ready <= 1'b0;
            end
            else
            begin
                cmd_ch.ready <= 1'b1;
                rdy_hold = pick_gap(rdy_quiet);
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        cmd_beat_t exp_cmd;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            if (cmds_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: target=%0d value=%0d",
                             cmd_ch.target, cmd_ch.value);
            end
            else
            begin
                exp_cmd = cmds_expected.pop_front();
                if (cmd_ch.target !== exp_cmd.target || cmd_ch.value !== exp_cmd.value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected target=%0d value=%0d, ",
                                  "got target=%0d value=%0d"},
                                 exp_cmd.target, exp_cmd.value,
                                 cmd_ch.target, cmd_ch.value);
                end
            end
        end
    end

    initial
    begin
        int r;
        int k;
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        cmd_ch.ready  = 1'b0;
        pend_cmd      = sspcp_pkg::CMD_NONE;
        digit_cnt     = '0;
        acc_value     = '0;
        beats_sent    = 0;
        useful        = 0;
        mismatches    = 0;
        tx_gap        = 0;
        tx_cycle      = 0;
        tx_quiet      = 1'b0;
        rdy_hold      = 0;
        rdy_cycle     = 0;
        rdy_quiet     = 1'b0;

        // Directed: min and max values, both targets, both line ends
        push_str("S0\n");
        push_str("a9999\r");
        // digit and line end with nothing pending
        push_str("5\r");
        // line end with no digit keeps the command; a new letter overrides
        push_str("s\nA1S7\r");
        // eighth digit ignored after seven leading zeros
        push_str("A00000009\n");
        // just above the limit: dropped
        push_str("s10000\r");
        tx_bytes.push_back(8'hFF);

        // Random: mostly well-formed commands, some noise and broken lines
        while (useful < 1800)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                push_cmd_letter();
                if ($urandom_range(0, 99) < 15)
                    for (int i = $urandom_range(1, 8); i > 0; i--)
                        push_byte(sspcp_pkg::CH_0);
                k = $urandom_range(0, 99);
                if (k < 12)
                    push_str($sformatf("%0d", $urandom_range(9990, 10009)));
                else if (k < 75)
                    push_digits($urandom_range(1, 4));
                else
                    push_digits($urandom_range(5, 9));
                push_line_end();
            end
            else if (r < 88)
            begin
                for (int i = $urandom_range(1, 4); i > 0; i--)
                    tx_bytes.push_back(sspcp_pkg::BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: push_line_end();
                    1:
                    begin
                        push_digits($urandom_range(1, 3));
                        push_line_end();
                    end
                    2:
                    begin
                        push_cmd_letter();
                        push_digits($urandom_range(0, 3));
                        push_cmd_letter();
                        push_digits($urandom_range(1, 4));
                        push_line_end();
                    end
                    3:
                    begin
                        push_cmd_letter();
                        push_line_end();
                        push_digits($urandom_range(1, 4));
                        push_line_end();
                    end
                    default:
                    begin
                        push_cmd_letter();
                        push_digits($urandom_range(1, 2));
                        tx_bytes.push_back(sspcp_pkg::BYTE_W'($urandom_range(128, 255)));
                        push_digits($urandom_range(1, 2));
                        push_line_end();
                    end
                endcase
            end
        end
        total_bytes = tx_bytes.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (beats_sent == total_bytes);
        for (int i = 0; i < 2000 && cmds_expected.size() != 0; i++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (cmds_expected.size() != 0)
        begin
            $display("%0d expected results never arrived", cmds_expected.size());
            mismatches += cmds_expected.size();
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
